// ===== sv/bso_pkg.sv =====
// shared constants for the box versus segment overlap block
`default_nettype none
package bso_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int PIPE_STAGES    = 3;

endpackage
`default_nettype wire

// ===== sv/bso_cross_axis.sv =====
// one cross-product separating axis: product register and final compare
`default_nettype none
module bso_cross_axis #(
    parameter int COORD_BITS = bso_pkg::COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [COORD_BITS+1:0]  i_ta,
    input  wire logic signed [COORD_BITS+1:0]  i_tb,
    input  wire logic signed [COORD_BITS:0]    i_ha,
    input  wire logic signed [COORD_BITS:0]    i_hb,
    input  wire logic        [COORD_BITS-1:0]  i_mha,
    input  wire logic        [COORD_BITS-1:0]  i_mhb,
    input  wire logic        [COORD_BITS-1:0]  i_ea,
    input  wire logic        [COORD_BITS-1:0]  i_eb,
    output logic                               o_sep
);

    localparam int PW = 2 * COORD_BITS + 3;
    localparam int UW = 2 * COORD_BITS;
    localparam int DW = 2 * COORD_BITS + 4;

    logic signed [PW-1:0] r_p;
    logic signed [PW-1:0] r_q;
    logic        [UW-1:0] r_ra;
    logic        [UW-1:0] r_rb;
    logic signed [PW-1:0] n_p;
    logic signed [PW-1:0] n_q;
    logic        [UW-1:0] n_ra;
    logic        [UW-1:0] n_rb;

    logic signed [DW-1:0] diff;
    logic        [DW-1:0] mag_diff;
    logic        [UW:0]   rhs;

    always_comb begin
        n_p  = PW'(i_ta) * PW'(i_hb);
        n_q  = PW'(i_tb) * PW'(i_ha);
        n_ra = UW'(i_ea) * UW'(i_mhb);
        n_rb = UW'(i_eb) * UW'(i_mha);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= n_p;
            r_q  <= n_q;
            r_ra <= n_ra;
            r_rb <= n_rb;
        end
    end

    always_comb begin
        diff     = DW'(r_p) - DW'(r_q);
        mag_diff = diff[DW-1] ? DW'(-diff) : DW'(diff);
        rhs      = (UW+1)'(r_ra) + (UW+1)'(r_rb);
        o_sep    = mag_diff > DW'(rhs);
    end

endmodule
`default_nettype wire

// ===== sv/box_segment_overlap_3d_top.sv =====
// top level of the box versus segment separating-axis overlap test
// throughput: one beat per cycle while the output is not stalled; three register stages with per-stage handshake
// stage 1 forms center offsets, half-vectors and extents, stage 2 the face results and axis products, stage 3 the flag
// a stalled result holds its stage while the earlier stages keep filling
// reset (synchronous, active low) clears the stage valid flags only
`default_nettype none
module box_segment_overlap_3d_top #(
    parameter int COORD_BITS = bso_pkg::COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [COORD_BITS-1:0] i_box_min_x,
    input  wire logic signed [COORD_BITS-1:0] i_box_min_y,
    input  wire logic signed [COORD_BITS-1:0] i_box_min_z,
    input  wire logic signed [COORD_BITS-1:0] i_box_max_x,
    input  wire logic signed [COORD_BITS-1:0] i_box_max_y,
    input  wire logic signed [COORD_BITS-1:0] i_box_max_z,
    input  wire logic signed [COORD_BITS-1:0] i_seg_begin_x,
    input  wire logic signed [COORD_BITS-1:0] i_seg_begin_y,
    input  wire logic signed [COORD_BITS-1:0] i_seg_begin_z,
    input  wire logic signed [COORD_BITS-1:0] i_seg_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_seg_end_y,
    input  wire logic signed [COORD_BITS-1:0] i_seg_end_z,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic                              o_overlap
);

    localparam int W = COORD_BITS;

    logic signed [W-1:0] bmin [3];
    logic signed [W-1:0] bmax [3];
    logic signed [W-1:0] sbeg [3];
    logic signed [W-1:0] send [3];

    logic signed [W+1:0] n_t  [3];
    logic signed [W:0]   n_h  [3];
    logic        [W-1:0] n_mh [3];
    logic        [W-1:0] n_e  [3];
    logic signed [W:0]   dbox [3];

    logic signed [W+1:0] r_t  [3];
    logic signed [W:0]   r_h  [3];
    logic        [W-1:0] r_mh [3];
    logic        [W-1:0] r_e  [3];

    logic        [W+1:0] mag_t [3];
    logic                n_face_sep;
    logic                r_face_sep;
    logic        [2:0]   cross_sep;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_overlap;
    logic en1;
    logic en2;
    logic en3;

    assign bmin[0] = i_box_min_x;
    assign bmin[1] = i_box_min_y;
    assign bmin[2] = i_box_min_z;
    assign bmax[0] = i_box_max_x;
    assign bmax[1] = i_box_max_y;
    assign bmax[2] = i_box_max_z;
    assign sbeg[0] = i_seg_begin_x;
    assign sbeg[1] = i_seg_begin_y;
    assign sbeg[2] = i_seg_begin_z;
    assign send[0] = i_seg_end_x;
    assign send[1] = i_seg_end_y;
    assign send[2] = i_seg_end_z;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;
    assign o_overlap = r_overlap;

    // doubled center offset, doubled half-vector and extents
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t[i]  = ((W+2)'(sbeg[i]) + (W+2)'(send[i]))
                    - ((W+2)'(bmin[i]) + (W+2)'(bmax[i]));
            n_h[i]  = (W+1)'(sbeg[i]) - (W+1)'(send[i]);
            dbox[i] = (W+1)'(bmax[i]) - (W+1)'(bmin[i]);
            n_mh[i] = n_h[i][W] ? W'(-n_h[i]) : W'(n_h[i]);
            n_e[i]  = dbox[i][W] ? W'(-dbox[i]) : W'(dbox[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_t[i]  <= n_t[i];
                r_h[i]  <= n_h[i];
                r_mh[i] <= n_mh[i];
                r_e[i]  <= n_e[i];
            end
        end
    end

    // face axes
    always_comb begin
        n_face_sep = 1'b0;
        for (int i = 0; i < 3; i++) begin
            mag_t[i] = r_t[i][W+1] ? (W+2)'(-r_t[i]) : (W+2)'(r_t[i]);
            if (mag_t[i] > ((W+2)'(r_e[i]) + (W+2)'(r_mh[i]))) begin
                n_face_sep = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_face_sep <= n_face_sep;
        end
    end

    // cross axes: y-z, x-z, x-y
    bso_cross_axis #(.COORD_BITS(COORD_BITS)) u_cross_yz (
        .i_clk (i_clk),
        .i_en  (en2 && r_v1),
        .i_ta  (r_t[1]),
        .i_tb  (r_t[2]),
        .i_ha  (r_h[1]),
        .i_hb  (r_h[2]),
        .i_mha (r_mh[1]),
        .i_mhb (r_mh[2]),
        .i_ea  (r_e[1]),
        .i_eb  (r_e[2]),
        .o_sep (cross_sep[0])
    );

    bso_cross_axis #(.COORD_BITS(COORD_BITS)) u_cross_xz (
        .i_clk (i_clk),
        .i_en  (en2 && r_v1),
        .i_ta  (r_t[0]),
        .i_tb  (r_t[2]),
        .i_ha  (r_h[0]),
        .i_hb  (r_h[2]),
        .i_mha (r_mh[0]),
        .i_mhb (r_mh[2]),
        .i_ea  (r_e[0]),
        .i_eb  (r_e[2]),
        .o_sep (cross_sep[1])
    );

    bso_cross_axis #(.COORD_BITS(COORD_BITS)) u_cross_xy (
        .i_clk (i_clk),
        .i_en  (en2 && r_v1),
        .i_ta  (r_t[0]),
        .i_tb  (r_t[1]),
        .i_ha  (r_h[0]),
        .i_hb  (r_h[1]),
        .i_mha (r_mh[0]),
        .i_mhb (r_mh[1]),
        .i_ea  (r_e[0]),
        .i_eb  (r_e[1]),
        .o_sep (cross_sep[2])
    );

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_overlap <= !(r_face_sep || (|cross_sep));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_v1 && !r_v2 && !r_v3))
        else $error("pipeline not empty after reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v1)
        else $error("accepted beat missing from first stage");

    a_stage_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && (!r_v3 || i_ready)) |=> o_valid)
        else $error("second stage beat did not reach the output");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !en2) |=> r_v1)
        else $error("stalled first stage beat lost");
`endif

endmodule
`default_nettype wire
